/* hdl/bwtd_pkg.sv */
// bwtd_pkg: request and response item types and field codes for the
// inverse bwt decoder. no dependencies.
`default_nettype none

package bwtd_pkg;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [6:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  out_symbol;
      logic [11:0] out_position;
      logic        done_res;
      logic        status;
   } rsp_item_type;

endpackage

`default_nettype wire

/* hdl/bwtd_ram.sv */
// bwtd_ram: generic simple dual-port ram, one write port and one read port
// with registered read data. no dependencies.
`default_nettype none

module bwtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bwt_inverse_decoder.sv */
// bwt_inverse_decoder: inverse burrows-wheeler transform by lf mapping.
// a load transfer reads the symbol count, then writes the count and the store.
// the last load adds a prefix-sum walk over the count ram.
// a fetch: start read, row read, next symbol; its result is queued at the fetch transfer.
// a two-entry result queue lets input transfers continue while a result waits.
// synchronous reset clears control state and symbol count valid bits; no ram clear pass.
// depends on bwtd_pkg and bwtd_ram.
`default_nettype none

module bwt_inverse_decoder #(
   parameter int MAX_LEN  = 4096,
   parameter int ALPHABET = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire bwtd_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bwtd_pkg::rsp_item_type     rsp_data
);

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int SYM_W  = $clog2(ALPHABET);
   localparam int DAT_W  = SYM_W + CNT_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOAD_WR = 3'd1;
   localparam logic [2:0] ST_WALK    = 3'd2;
   localparam logic [2:0] ST_ROW     = 3'd3;
   localparam logic [2:0] ST_LF      = 3'd4;

   localparam logic [1:0] PH_LOAD = 2'd0;
   localparam logic [1:0] PH_DEC  = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cur_rank_ff, cur_rank_in;
   logic [SYM_W-1:0]  cur_sym_ff, cur_sym_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic [1:0]        qcnt_ff, qcnt_in;
   logic [ALPHABET-1:0] vbits_ff, vbits_in;
   bwtd_pkg::rsp_item_type q0_ff, q0_in, q1_ff, q1_in;

   logic              ld_ok_ff, ld_ok_in;
   logic              ld_last_ff, ld_last_in;
   logic [SYM_W-1:0]  ld_idx_ff, ld_idx_in;
   logic [SYM_W:0]    walk_rd_ff, walk_rd_in;
   logic              wb_vld_ff, wb_vld_in;
   logic [SYM_W-1:0]  wb_addr_ff, wb_addr_in;
   logic [CNT_W-1:0]  sum_ff, sum_in;
   logic              found_ff, found_in;
   logic              row_ok_ff, row_ok_in;
   logic              vbit_q_ff;

   logic              req_fire, rsp_fire, push;
   bwtd_pkg::rsp_item_type push_item;
   logic [8:0]        byte_ext;
   logic [SYM_W-1:0]  byte_idx;
   logic              byte_ok;
   logic [CNT_W-1:0]  count_rd, count_new, pos;
   logic [CNT_W:0]    row;
   logic [8:0]        sym_ext;
   logic [CNT_W+11:0] pos_ext;

   logic              sym_we;
   logic [SYM_W-1:0]  sym_waddr, sym_raddr;
   logic [CNT_W-1:0]  sym_wdata, sym_rdata;
   logic              dat_we;
   logic [ADDR_W-1:0] dat_waddr, dat_raddr;
   logic [DAT_W-1:0]  dat_wdata, dat_rdata;

   // symbol counts, turned into symbol start rows by the walk
   bwtd_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (sym_waddr),
      .wr_data (sym_wdata),
      .rd_addr (sym_raddr),
      .rd_data (sym_rdata)
   );

   // transformed byte and its occurrence rank per row
   bwtd_ram #(.WIDTH(DAT_W), .DEPTH(MAX_LEN)) u_dat_ram (
      .clock   (clock),
      .wr_en   (dat_we),
      .wr_addr (dat_waddr),
      .wr_data (dat_wdata),
      .rd_addr (dat_raddr),
      .rd_data (dat_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE) || (qcnt_ff == 2'd2);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (qcnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign rsp_data  = q0_ff;

   assign byte_ext  = {2'b00, req_data.data_byte};
   assign byte_idx  = byte_ext[SYM_W-1:0];
   assign byte_ok   = (byte_ext < 9'(ALPHABET));
   assign count_rd  = vbit_q_ff ? sym_rdata : '0;
   assign count_new = count_rd + CNT_W'(1);
   assign pos       = emit_ff - CNT_W'(1);
   assign pos_ext   = {12'd0, pos};
   assign sym_ext   = {(9 - SYM_W)'(0), cur_sym_ff};
   assign row       = {1'b0, sym_rdata} + {1'b0, cur_rank_ff} - (CNT_W + 1)'(1);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      len_in      = len_ff;
      cur_rank_in = cur_rank_ff;
      cur_sym_in  = cur_sym_ff;
      emit_in     = emit_ff;
      vbits_in    = vbits_ff;
      ld_ok_in    = ld_ok_ff;
      ld_last_in  = ld_last_ff;
      ld_idx_in   = ld_idx_ff;
      walk_rd_in  = walk_rd_ff;
      wb_vld_in   = 1'b0;
      wb_addr_in  = wb_addr_ff;
      sum_in      = sum_ff;
      found_in    = found_ff;
      row_ok_in   = row_ok_ff;
      push        = 1'b0;
      push_item   = '0;
      sym_we      = 1'b0;
      sym_waddr   = ld_idx_ff;
      sym_wdata   = count_new;
      sym_raddr   = byte_idx;
      dat_we      = 1'b0;
      dat_waddr   = len_ff[ADDR_W-1:0];
      dat_wdata   = {ld_idx_ff, count_new};
      dat_raddr   = row[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.req_type == bwtd_pkg::REQ_LOAD) begin
               if (phase_ff == PH_LOAD) begin
                  ld_ok_in   = byte_ok && (len_ff < CNT_W'(MAX_LEN));
                  ld_last_in = req_data.last_byte;
                  ld_idx_in  = byte_idx;
                  state_in   = ST_LOAD_WR;
               end
            end else if (req_fire) begin
               push = 1'b1;
               sym_raddr = cur_sym_ff;
               if (phase_ff == PH_DEC && emit_ff != '0) begin
                  push_item.out_symbol   = sym_ext[6:0];
                  push_item.out_position = pos_ext[11:0];
                  push_item.done_res     = (pos == '0);
                  push_item.status       = bwtd_pkg::STATUS_OK;
                  emit_in  = pos;
                  if (pos == '0) begin
                     phase_in = PH_DONE;
                  end
                  state_in = ST_ROW;
               end else begin
                  push_item.status = bwtd_pkg::STATUS_NOT_READY;
               end
            end
         end
         ST_LOAD_WR: begin
            if (ld_ok_ff) begin
               sym_we              = 1'b1;
               dat_we              = 1'b1;
               vbits_in[ld_idx_ff] = 1'b1;
               len_in              = len_ff + CNT_W'(1);
            end
            if (ld_last_ff) begin
               walk_rd_in = '0;
               sum_in     = '0;
               found_in   = 1'b0;
               state_in   = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            sym_raddr = walk_rd_ff[SYM_W-1:0];
            if (walk_rd_ff < (SYM_W + 1)'(ALPHABET)) begin
               wb_vld_in  = 1'b1;
               wb_addr_in = walk_rd_ff[SYM_W-1:0];
               walk_rd_in = walk_rd_ff + (SYM_W + 1)'(1);
            end
            if (wb_vld_ff) begin
               sym_we    = 1'b1;
               sym_waddr = wb_addr_ff;
               sym_wdata = sum_ff;
               sum_in    = sum_ff + count_rd;
               if (!found_ff && count_rd != '0) begin
                  found_in   = 1'b1;
                  cur_sym_in = wb_addr_ff;
               end
            end else if (walk_rd_ff == (SYM_W + 1)'(ALPHABET)) begin
               cur_rank_in = CNT_W'(1);
               emit_in     = len_ff;
               phase_in    = (len_ff == '0) ? PH_DONE : PH_DEC;
               state_in    = ST_IDLE;
            end
         end
         ST_ROW: begin
            row_ok_in = (row < {1'b0, len_ff});
            state_in  = ST_LF;
         end
         ST_LF: begin
            if (row_ok_ff) begin
               cur_sym_in  = dat_rdata[DAT_W-1:CNT_W];
               cur_rank_in = dat_rdata[CNT_W-1:0];
            end else begin
               cur_sym_in  = '0;
               cur_rank_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // two-entry result queue
   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff + {1'b0, push} - {1'b0, rsp_fire};
      if (push && (qcnt_ff == 2'd0 || (qcnt_ff == 2'd1 && rsp_fire))) begin
         q0_in = push_item;
      end else if (rsp_fire && qcnt_ff == 2'd2) begin
         q0_in = q1_ff;
      end
      if (push && ((qcnt_ff == 2'd1 && !rsp_fire) || (qcnt_ff == 2'd2 && rsp_fire))) begin
         q1_in = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_LOAD;
         len_ff      <= '0;
         cur_rank_ff <= CNT_W'(1);
         cur_sym_ff  <= '0;
         emit_ff     <= '0;
         qcnt_ff     <= '0;
         vbits_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         len_ff      <= len_in;
         cur_rank_ff <= cur_rank_in;
         cur_sym_ff  <= cur_sym_in;
         emit_ff     <= emit_in;
         qcnt_ff     <= qcnt_in;
         vbits_ff    <= vbits_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
      ld_ok_ff   <= ld_ok_in;
      ld_last_ff <= ld_last_in;
      ld_idx_ff  <= ld_idx_in;
      walk_rd_ff <= walk_rd_in;
      wb_vld_ff  <= wb_vld_in;
      wb_addr_ff <= wb_addr_in;
      sum_ff     <= sum_in;
      found_ff   <= found_in;
      row_ok_ff  <= row_ok_in;
      vbit_q_ff  <= vbits_ff[sym_raddr];
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> qcnt_ff != 2'd2)
      else $error("result pushed into a full queue");

   a_row_after_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW |-> $past(req_fire && req_data.req_type == bwtd_pkg::REQ_FETCH))
      else $error("row lookup without a fetch transfer");

   a_emit_bounded: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= len_ff)
      else $error("emit index beyond loaded length");

   a_walk_leaves_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && state_in == ST_IDLE) |=> phase_ff != PH_LOAD)
      else $error("walk finished without leaving load phase");

   a_no_load_after_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_LOAD |=> len_ff == $past(len_ff))
      else $error("store grew after loading ended");

endmodule

`default_nettype wire

/* bench/bwt_inverse_decoder_test.sv */
// bwt_inverse_decoder_test: loads one transformed string, decodes it symbol by symbol
// and checks every response against an lf-mapping predictor kept in the bench.
// depends on bwtd_pkg and the bwt_inverse_decoder rtl.
`default_nettype none

module bwt_inverse_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH     = 4096;
   localparam int SYMBOLS         = 128;
   localparam int LOAD_BYTES      = 400;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;

   typedef enum logic [1:0] {LOADING, DECODING, FINISHED} decode_phase_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   bwtd_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   bwtd_pkg::rsp_item_type rsp_data;

   // predictor state
   logic [6:0]             text_store [STORE_DEPTH];
   logic [12:0]            rank_of_row [STORE_DEPTH];
   logic [12:0]            sym_total [SYMBOLS] = '{default: '0};
   logic [12:0]            sym_first_row [SYMBOLS];
   logic [12:0]            stored_len = '0;
   logic [12:0]            next_rank = 13'd1;
   logic [6:0]             next_sym = '0;
   logic [12:0]            rows_left = '0;
   decode_phase_type       dec_phase = LOADING;
   bwtd_pkg::rsp_item_type expected_symbols [$];

   int   failures = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   logic hold_off_request = 1'b0;

   bwt_inverse_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bwtd_pkg::req_item_type make_req(logic kind, logic [6:0] data,
                                                       logic last);
      bwtd_pkg::req_item_type item;
      item.req_type  = kind;
      item.data_byte = data;
      item.last_byte = last;
      return item;
   endfunction

   function automatic void predict_decoder(bwtd_pkg::req_item_type item);
      logic [12:0]            row_sum;
      logic [12:0]            row;
      logic                   found;
      bwtd_pkg::rsp_item_type res;
      if (item.req_type == bwtd_pkg::REQ_LOAD) begin
         if (dec_phase != LOADING) return;
         if (stored_len < STORE_DEPTH) begin
            sym_total[item.data_byte] = sym_total[item.data_byte] + 13'd1;
            text_store[stored_len]    = item.data_byte;
            rank_of_row[stored_len]   = sym_total[item.data_byte];
            stored_len                = stored_len + 13'd1;
         end
         if (item.last_byte) begin
            row_sum = '0;
            found   = 1'b0;
            for (int s = 0; s < SYMBOLS; s++) begin
               sym_first_row[s] = row_sum;
               if (sym_total[s] != 0 && !found) begin
                  found    = 1'b1;
                  next_sym = 7'(s);
               end
               row_sum = row_sum + sym_total[s];
            end
            next_rank = 13'd1;
            rows_left = stored_len;
            dec_phase = (stored_len == 0) ? FINISHED : DECODING;
         end
         return;
      end
      res = '0;
      if (dec_phase != DECODING || rows_left == 0) begin
         res.status = bwtd_pkg::STATUS_NOT_READY;
      end else begin
         row              = sym_first_row[next_sym] + next_rank - 13'd1;
         res.out_symbol   = next_sym;
         res.out_position = 12'(rows_left - 13'd1);
         res.done_res     = (rows_left == 13'd1);
         res.status       = bwtd_pkg::STATUS_OK;
         if (row < stored_len) begin
            next_rank = rank_of_row[row];
            next_sym  = text_store[row];
         end else begin
            next_rank = '0;
            next_sym  = '0;
         end
         rows_left = rows_left - 13'd1;
         if (rows_left == 0) dec_phase = FINISHED;
      end
      expected_symbols.push_back(res);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input bwtd_pkg::req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_decoder(item);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_symbols.size() != 0);
   endtask

   task automatic test_fetch_before_load();
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h00, 1'b0));
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h7F, 1'b1));
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h2A, 1'b0));
   endtask

   task automatic test_load_string();
      logic [6:0] seed_bytes [6] = '{7'h00, 7'h7F, 7'h55, 7'h2A, 7'h01, 7'h40};
      logic [6:0] data;
      int         loaded;
      foreach (seed_bytes[i]) send_item(make_req(bwtd_pkg::REQ_LOAD, seed_bytes[i], 1'b0));
      loaded = 6;
      while (loaded < LOAD_BYTES - 1) begin
         if ($urandom_range(99) < 3) begin
            send_item(make_req(bwtd_pkg::REQ_FETCH, 7'($urandom), 1'($urandom)));
         end else begin
            if ($urandom_range(99) < 40) data = 7'h61 + 7'($urandom_range(2));
            else data = 7'($urandom_range(127));
            send_item(make_req(bwtd_pkg::REQ_LOAD, data, 1'b0));
            loaded++;
         end
      end
      // the marked byte is stored and ends loading
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h33, 1'b1));
   endtask

   task automatic test_load_after_end();
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h00, 1'b1));
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h7F, 1'b0));
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h15, 1'b1));
   endtask

   task automatic test_decode(input int count);
      int fetched;
      fetched = 0;
      while (fetched < count && rows_left != 0) begin
         if ($urandom_range(99) < 4) begin
            send_item(make_req(bwtd_pkg::REQ_LOAD, 7'($urandom), 1'($urandom)));
         end else begin
            send_item(make_req(bwtd_pkg::REQ_FETCH, 7'($urandom), 1'($urandom)));
            fetched++;
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      hold_off_request = 1'b1;
      @(negedge clock);
      repeat (32) send_item(make_req(bwtd_pkg::REQ_FETCH, 7'($urandom), 1'b0));
      wait_for_results();
   endtask

   task automatic test_after_decode();
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h7F, 1'b1));
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h00, 1'b1));
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h00, 1'b0));
      send_item(make_req(bwtd_pkg::REQ_LOAD, 7'h7F, 1'b0));
      send_item(make_req(bwtd_pkg::REQ_FETCH, 7'h55, 1'b0));
   endtask

   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_left        = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      bwtd_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            $error("result with nothing expected: symbol %0d position %0d status %0d",
                   rsp_data.out_symbol, rsp_data.out_position, rsp_data.status);
            failures++;
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_data.out_symbol !== want.out_symbol) begin
               $error("out_symbol expected %0d got %0d", want.out_symbol, rsp_data.out_symbol);
               failures++;
            end
            if (rsp_data.out_position !== want.out_position) begin
               $error("out_position expected %0d got %0d",
                      want.out_position, rsp_data.out_position);
               failures++;
            end
            if (rsp_data.done_res !== want.done_res) begin
               $error("done_res expected %0d got %0d", want.done_res, rsp_data.done_res);
               failures++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      rsp_stall_pct = 55;
      test_fetch_before_load();
      test_load_string();
      test_load_after_end();
      test_decode(150);
      test_backpressure();
      send_idle_pct = 55;
      rsp_stall_pct = 24;
      test_decode(150);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_decode(STORE_DEPTH);
      test_after_decode();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
